// File: sv/omni_wheel_drive_mixer_defines.svh
// Assertion macros shared by the checker of the omni wheel drive mixer.
// Every macro samples on aclk; the first one is disabled while aresetn is low.
`ifndef OMNI_WHEEL_DRIVE_MIXER_DEFINES_SVH
`define OMNI_WHEEL_DRIVE_MIXER_DEFINES_SVH

`define OWDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define OWDM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: sv/owdm_pkg.sv
// Shared constants, types and the CORDIC arctangent table of the omni wheel drive mixer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package owdm_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 15;
    localparam int CORDIC_STEPS = (FRAC_BITS < 24) ? FRAC_BITS : 24;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int XY_W         = FRAC_BITS + 5;
    localparam int COS_W        = FRAC_BITS + 2;
    localparam int RAW_W        = FRAC_BITS + 12;
    localparam int MAG_W        = FRAC_BITS + 11;
    localparam int NUM_W        = MAG_W + 8;
    localparam int Z_W          = 33;
    localparam longint GAIN_Q30 = 64'd652032874;
    localparam longint X_INIT   = (GAIN_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    localparam int CFG_W        = 16;
    localparam int IN_W         = 40;
    localparam int OUT_W        = 56;

    localparam logic [1:0] REG_WHEEL0_ANGLE = 2'd0;
    localparam logic [1:0] REG_WHEEL1_ANGLE = 2'd1;
    localparam logic [1:0] REG_WHEEL2_ANGLE = 2'd2;
    localparam logic [1:0] REG_POWER_LIMIT  = 2'd3;

    typedef logic [ANGLE_BITS-1:0] angle_t;

    typedef struct packed {
        angle_t [2:0]      diff;
        logic signed [8:0] spd;
        logic signed [8:0] rot;
    } entry_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/owdm_front.sv
// Front end: accepts input words, forms the three wheel angle differences
// and holds them in a two-entry queue. Depends on owdm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module owdm_front (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [owdm_pkg::IN_W-1:0] s_tdata,
    input  wire owdm_pkg::angle_t [2:0]   wheel_angle,
    output logic                          q_valid,
    input  wire logic                     q_ready,
    output owdm_pkg::entry_t              q_entry
);
    import owdm_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    entry_t     new_entry;
    logic       push, pop;
    angle_t     heading;

    assign heading  = s_tdata[ANGLE_BITS-1:0];
    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            new_entry.diff[i] = heading - wheel_angle[i];
        end
        new_entry.spd = s_tdata[24:16];
        new_entry.rot = s_tdata[33:25];
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= new_entry;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/owdm_back.sv
// Back end: three-lane CORDIC cosine, drive mixing, peak search and
// bit-serial normalizing divide, ending in the output register. Depends on owdm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module owdm_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      q_valid,
    output logic                           q_ready,
    input  wire owdm_pkg::entry_t          q_entry,
    input  wire logic [7:0]                power_limit,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [owdm_pkg::OUT_W-1:0]     m_tdata
);
    import owdm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROT  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_PEAK = 3'd3;
    localparam logic [2:0] ST_PROD = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]              state_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic [2:0]              bit_reg;
    logic signed [XY_W-1:0]  x_reg [3];
    logic signed [XY_W-1:0]  y_reg [3];
    logic signed [Z_W-1:0]   z_reg [3];
    logic [2:0]              flip_reg;
    logic signed [8:0]       spd_reg, rot_reg;
    logic signed [RAW_W-1:0] raw_reg [3];
    logic [MAG_W-1:0]        mag_reg [3];
    logic [2:0]              neg_reg;
    logic [MAG_W-1:0]        peak_reg;
    logic [7:0]              tgt_reg;
    logic [NUM_W-1:0]        rem_reg [3];
    logic [7:0]              quo_reg [3];
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;

    logic [31:0]             atan_val;
    logic                    out_free;
    logic [OUT_W-1:0]        out_word;
    logic [MAG_W-1:0]        mag_c [3];
    logic [MAG_W-1:0]        peak_c;
    logic [9:0]              sum_c;

    assign q_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign atan_val = atan_turn(5'(iter_reg));

    always_comb begin
        peak_c = '0;
        for (int i = 0; i < 3; i++) begin
            mag_c[i] = raw_reg[i][RAW_W-1] ? MAG_W'(-raw_reg[i]) : MAG_W'(raw_reg[i]);
            if (mag_c[i] > peak_c) begin
                peak_c = mag_c[i];
            end
        end
        sum_c = 10'(spd_reg[8] ? -10'(spd_reg) : 10'(spd_reg))
              + 10'(rot_reg[8] ? -10'(rot_reg) : 10'(rot_reg));
    end

    always_comb begin
        logic [7:0] qq;
        logic       neg_out;
        logic [8:0] drv;
        out_word = '0;
        for (int i = 0; i < 3; i++) begin
            qq      = (peak_reg == '0) ? 8'd0 : quo_reg[i];
            neg_out = neg_reg[i] && (qq != 8'd0);
            drv     = neg_reg[i] ? -{1'b0, qq} : {1'b0, qq};
            out_word[9*i +: 9]       = drv;
            out_word[27 + 8*i +: 8]  = {neg_out, (qq > 8'd127) ? 7'd127 : qq[6:0]};
            out_word[51 + i]         = neg_reg[i] || (qq == 8'd0);
        end
    end

    always_ff @(posedge aclk) begin
        logic [ANGLE_BITS-1:0]    d;
        logic [ANGLE_BITS-1:0]    dq;
        logic                     fl;
        logic signed [XY_W-1:0]   cx;
        logic signed [COS_W-1:0]  cs;
        logic [NUM_W-1:0]         den;
        unique case (state_reg)
            ST_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    d  = q_entry.diff[i];
                    dq = d + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
                    fl = dq[ANGLE_BITS-1];
                    if (fl) begin
                        d = d ^ ANGLE_BITS'(1 << (ANGLE_BITS - 1));
                    end
                    flip_reg[i] <= fl;
                    z_reg[i] <= Z_W'(signed'({d, {(32 - ANGLE_BITS){1'b0}}}));
                    x_reg[i] <= XY_W'(X_INIT);
                    y_reg[i] <= '0;
                end
                spd_reg  <= q_entry.spd;
                rot_reg  <= q_entry.rot;
                iter_reg <= '0;
            end
            ST_ROT: begin
                for (int i = 0; i < 3; i++) begin
                    if (!z_reg[i][Z_W-1]) begin
                        x_reg[i] <= x_reg[i] - (y_reg[i] >>> iter_reg);
                        y_reg[i] <= y_reg[i] + (x_reg[i] >>> iter_reg);
                        z_reg[i] <= z_reg[i] - Z_W'(atan_val);
                    end else begin
                        x_reg[i] <= x_reg[i] + (y_reg[i] >>> iter_reg);
                        y_reg[i] <= y_reg[i] - (x_reg[i] >>> iter_reg);
                        z_reg[i] <= z_reg[i] + Z_W'(atan_val);
                    end
                end
                iter_reg <= iter_reg + ITER_W'(1);
            end
            ST_MUL: begin
                for (int i = 0; i < 3; i++) begin
                    cx = x_reg[i];
                    if (cx > XY_W'(1 << FRAC_BITS)) begin
                        cx = XY_W'(1 << FRAC_BITS);
                    end
                    if (cx < -XY_W'(1 << FRAC_BITS)) begin
                        cx = -XY_W'(1 << FRAC_BITS);
                    end
                    cs = flip_reg[i] ? -cx[COS_W-1:0] : cx[COS_W-1:0];
                    raw_reg[i] <= RAW_W'(spd_reg * cs) + (RAW_W'(rot_reg) <<< FRAC_BITS);
                end
            end
            ST_PEAK: begin
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i] <= mag_c[i];
                    neg_reg[i] <= raw_reg[i][RAW_W-1];
                end
                peak_reg <= peak_c;
                tgt_reg  <= (sum_c > 10'(power_limit)) ? power_limit : sum_c[7:0];
            end
            ST_PROD: begin
                for (int i = 0; i < 3; i++) begin
                    rem_reg[i] <= NUM_W'(mag_reg[i]) * NUM_W'(tgt_reg);
                    quo_reg[i] <= '0;
                end
                bit_reg <= 3'd7;
            end
            ST_DIV: begin
                den = NUM_W'(peak_reg) << bit_reg;
                for (int i = 0; i < 3; i++) begin
                    if (rem_reg[i] >= den) begin
                        rem_reg[i] <= rem_reg[i] - den;
                        quo_reg[i][bit_reg] <= 1'b1;
                    end
                end
                bit_reg <= bit_reg - 3'd1;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= out_word;
                end
            end
            default: begin
            end
        endcase

        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: if (q_valid) state_reg <= ST_ROT;
                ST_ROT:  if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) state_reg <= ST_MUL;
                ST_MUL:  state_reg <= ST_PEAK;
                ST_PEAK: state_reg <= ST_PROD;
                ST_PROD: state_reg <= ST_DIV;
                ST_DIV:  if (bit_reg == 3'd0) state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/omni_wheel_drive_mixer.sv
// Top level of the three-wheel omni drive mixer: configuration registers,
// front end with queue, and back end. Depends on owdm_pkg, owdm_front, owdm_back.
//
// In the back end each word passes one load, 15 CORDIC iterations shared by the
// three wheel lanes, mix, peak, product, an 8-step restoring divide and the output
// load. The front queue holds two words, so input is taken while the back end works
// and while a result waits, until the queue is full. The user must write the power
// limit and wheel angles via cfg_wr_* only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module omni_wheel_drive_mixer (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // heading[15:0], speed[24:16], rotation[33:25], zero pad
    input  wire logic [owdm_pkg::IN_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // wheel0_drive[8:0], wheel1_drive[17:9], wheel2_drive[26:18], wheel0_code[34:27],
    // wheel1_code[42:35], wheel2_code[50:43], reverse_mask[53:51], zero pad
    output logic [owdm_pkg::OUT_W-1:0]      m_tdata,
    input  wire logic                       cfg_wr_en,
    input  wire logic [1:0]                 cfg_wr_addr,
    input  wire logic [owdm_pkg::CFG_W-1:0] cfg_wr_data
);
    import owdm_pkg::*;

    angle_t [2:0] angle_reg;
    logic [7:0]   power_limit_reg;
    logic         q_valid, q_ready;
    entry_t       q_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg[0]    <= ANGLE_BITS'(0);
            angle_reg[1]    <= ANGLE_BITS'(21845);
            angle_reg[2]    <= ANGLE_BITS'(43691);
            power_limit_reg <= 8'd100;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                REG_WHEEL0_ANGLE: angle_reg[0] <= cfg_wr_data[ANGLE_BITS-1:0];
                REG_WHEEL1_ANGLE: angle_reg[1] <= cfg_wr_data[ANGLE_BITS-1:0];
                REG_WHEEL2_ANGLE: angle_reg[2] <= cfg_wr_data[ANGLE_BITS-1:0];
                REG_POWER_LIMIT:  power_limit_reg <= cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    owdm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .wheel_angle (angle_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_entry     (q_entry)
    );

    owdm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_entry     (q_entry),
        .power_limit (power_limit_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
`default_nettype wire

// File: sv/owdm_checker.sv
// Port-level checker of the omni wheel drive mixer and its bind to the top level.
// Depends on owdm_pkg and omni_wheel_drive_mixer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "omni_wheel_drive_mixer_defines.svh"
module owdm_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [owdm_pkg::OUT_W-1:0] m_tdata
);
    `OWDM_ASSERT_RST(a_reset_clears, !aresetn |=> !m_tvalid, "output word valid after reset")
    `OWDM_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "stalled word dropped")
    `OWDM_ASSERT(a_mask0, m_tvalid |-> (m_tdata[51] == (m_tdata[8] || (m_tdata[8:0] == 9'd0))), "reverse bit of wheel 0 disagrees with drive")
    `OWDM_ASSERT(a_code0, m_tvalid |-> (m_tdata[34] == m_tdata[8]), "sign of wheel 0 code disagrees with drive")
endmodule

bind omni_wheel_drive_mixer owdm_checker u_owdm_checker (.*);
`default_nettype wire

// File: sim/omni_wheel_drive_mixer_tb.sv
// Self-checking bench for omni_wheel_drive_mixer: drives heading/speed/rotation words,
// predicts wheel drives, codes and reverse mask with an integer CORDIC, checks results.
// Depends on owdm_pkg and the RTL of omni_wheel_drive_mixer.
`timescale 1ns / 1ps
`default_nettype none
module omni_wheel_drive_mixer_tb;
    import owdm_pkg::*;

    localparam int  GAP_LIMIT  = 4000;
    localparam int  DRAIN_WAIT = 80;
    localparam int  N_RANDOM   = 930;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_wr_addr = REG_WHEEL0_ANGLE;
    logic [CFG_W-1:0]      cfg_wr_data = '0;

    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;
    int n_words = 0;
    int n_checked = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    omni_wheel_drive_mixer u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_addr(cfg_wr_addr), .cfg_wr_data(cfg_wr_data)
    );

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    class mixer_scoreboard;
        logic [15:0]      angle [3];
        logic [7:0]       limit;
        logic [OUT_W-1:0] pending [$];

        function new();
            angle[0] = 16'd0; angle[1] = 16'd21845; angle[2] = 16'd43691;
            limit = 8'd100;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] v);
            if (idx == REG_POWER_LIMIT) limit = v[7:0];
            else angle[idx] = v;
        endfunction

        static function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        static function longint cos_q(logic [31:0] a);
            longint x, y, z, nx, one;
            bit flip;
            flip = 0;
            if (((a + 32'h40000000) & 32'h80000000) != 0) begin
                a = a + 32'h80000000;
                flip = 1;
            end
            z = longint'($signed(a));
            x = (64'd652032874 + (64'd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - fshift(y, i);
                    y = y + fshift(x, i);
                    z = z - longint'(atan_turn(i[4:0]));
                end else begin
                    nx = x + fshift(y, i);
                    y = y - fshift(x, i);
                    z = z + longint'(atan_turn(i[4:0]));
                end
                x = nx;
            end
            one = longint'(1) << FRAC_BITS;
            if (x > one) x = one;
            if (x < -one) x = -one;
            return flip ? -x : x;
        endfunction

        function void note_word(logic [IN_W-1:0] w);
            logic [15:0]      head, d;
            longint           spd, rot, peak, tgt, mag, drv;
            longint           raw [3];
            logic [OUT_W-1:0] r;
            logic [7:0]       cm;
            head = w[15:0];
            spd = longint'($signed(w[24:16]));
            rot = longint'($signed(w[33:25]));
            peak = 0;
            for (int i = 0; i < 3; i++) begin
                d = head - angle[i];
                raw[i] = spd * cos_q({d, 16'h0}) + rot * (longint'(1) << FRAC_BITS);
                mag = raw[i] < 0 ? -raw[i] : raw[i];
                if (mag > peak) peak = mag;
            end
            tgt = (spd < 0 ? -spd : spd) + (rot < 0 ? -rot : rot);
            if (tgt > limit) tgt = limit;
            r = '0;
            for (int i = 0; i < 3; i++) begin
                if (peak == 0) drv = 0;
                else begin
                    mag = raw[i] < 0 ? -raw[i] : raw[i];
                    mag = mag * tgt / peak;
                    drv = raw[i] < 0 ? -mag : mag;
                end
                mag = drv < 0 ? -drv : drv;
                cm = mag > 127 ? 8'd127 : mag[7:0];
                if (drv < 0) cm[7] = 1'b1;
                r[9*i +: 9] = drv[8:0];
                r[27 + 8*i +: 8] = cm;
                r[51 + i] = (drv <= 0);
            end
            pending.push_back(r);
        endfunction

        task check_word(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word", got, 0);
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got[9*i +: 9] !== want[9*i +: 9])
                    report_mismatch($sformatf("wheel%0d_drive", i),
                        $signed(got[9*i +: 9]), $signed(want[9*i +: 9]));
                if (got[27 + 8*i +: 8] !== want[27 + 8*i +: 8])
                    report_mismatch($sformatf("wheel%0d_code", i),
                        got[27 + 8*i +: 8], want[27 + 8*i +: 8]);
            end
            if (got[53:51] !== want[53:51])
                report_mismatch("reverse_mask", got[53:51], want[53:51]);
        endtask
    endclass

    mixer_scoreboard drive_sb = new();

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                drive_sb.note_word(s_tdata);
                n_words++;
            end
            if (m_tvalid && m_tready) begin
                drive_sb.check_word(m_tdata);
                n_checked++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= GAP_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(input logic [15:0] head, input logic [8:0] spd,
                             input logic [8:0] rot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, rot, spd, head};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (drive_sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        drive_sb.set_reg(idx, v);
        @(posedge aclk);
    endtask

    task automatic random_word();
        logic [8:0] spd, rot;
        spd = $urandom_range(9) == 0 ? 9'h100 : 9'($urandom);
        rot = $urandom_range(4) == 0 ? 9'd0 : 9'($urandom);
        if ($urandom_range(9) == 0) spd = 9'd0;
        send_word(16'($urandom), spd, rot);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(16'd0, 9'd0, 9'd0);
        send_word(16'hFFFF, 9'd255, 9'd0);
        send_word(16'd0, 9'h100, 9'h100);
        send_word(16'd16384, 9'h101, 9'd255);
        send_word(16'd21845, 9'd0, 9'h1FF);
        send_word(16'd32768, 9'd1, 9'd0);
        send_word(16'd49152, 9'd100, 9'h19C);
        send_word(16'd8192, 9'h0FF, 9'h0FF);
        drain();
        write_reg(REG_POWER_LIMIT, 16'd255);
        write_reg(REG_WHEEL0_ANGLE, 16'hFFFF);
        send_word(16'hFFFF, 9'h100, 9'd0);
        send_word(16'd0, 9'd255, 9'h101);
        send_word(16'd1234, 9'd7, 9'd3);
        drain();
        write_reg(REG_POWER_LIMIT, 16'd0);
        send_word(16'd5000, 9'd200, 9'd50);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = ph < 2 ? 20 : (ph < 4 ? 51 : 0);
            recv_idle_pct = ph < 2 ? 51 : (ph < 4 ? 20 : 0);
            drain();
            write_reg(REG_WHEEL0_ANGLE, 16'($urandom));
            write_reg(REG_WHEEL1_ANGLE, ph == 1 ? 16'hFFFF : 16'($urandom));
            write_reg(REG_WHEEL2_ANGLE, ph == 2 ? 16'd0 : 16'($urandom));
            write_reg(REG_POWER_LIMIT, ph == 3 ? 16'd1 : 16'($urandom_range(255)));
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                random_word();
                if (k == 60) drain();
            end
        end

        drain();
        $display("covered %0d words, %0d results checked, across nine register settings",
                 n_words, n_checked);
        $display("with sender and receiver stalls in both ratios and a stall-free stretch");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
+incdir+sv
sv/owdm_pkg.sv
sv/owdm_front.sv
sv/owdm_back.sv
sv/omni_wheel_drive_mixer.sv
sv/owdm_checker.sv
sim/omni_wheel_drive_mixer_tb.sv
